[src/knfs_pkg.sv]
// ----------------------------------------------------------------------------
// knfs_pkg: shared types and constants
// Field widths, register indexes and the controller/datapath command and
// status groups of the k nearest free node selector.
// ----------------------------------------------------------------------------
package knfs_pkg;

  localparam int ID_W      = 16;
  localparam int COORD_W   = 16;
  localparam int COST_W    = 8;
  localparam int RANK_W    = 4;
  localparam int NCOUNT_W  = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  // cells at or above this cost are blocked
  localparam logic [COST_W-1:0] COST_LIMIT = 8'd254;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_QUERY_X        = 2'd0,
    CFG_QUERY_Y        = 2'd1,
    CFG_NEIGHBOR_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic take;    // ready for a new node
    logic mul;     // square the coordinate deltas
    logic sum;     // add the squares
    logic insert;  // sorted insert into the kept list
    logic emit;    // load the next result beat
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;        // node under work ends the search
    logic out_free;    // output register can take a beat
    logic final_beat;  // at most one kept entry remains
  } dp_sts_t;

endpackage

[src/knfs_in_if.sv]
// ----------------------------------------------------------------------------
// knfs_in_if: node input channel
// Valid/ready channel carrying one graph node per beat.
// ----------------------------------------------------------------------------
interface knfs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] node_id;
  logic [15:0] node_x;
  logic [15:0] node_y;
  logic [7:0]  cell_cost;
  logic        outside_map;
  logic        last_node;

  modport source (
    output valid, node_id, node_x, node_y, cell_cost, outside_map, last_node,
    input  ready
  );
  modport sink (
    input  valid, node_id, node_x, node_y, cell_cost, outside_map, last_node,
    output ready
  );
endinterface

[src/knfs_out_if.sv]
// ----------------------------------------------------------------------------
// knfs_out_if: result channel
// Valid/ready channel carrying one selected node id per beat.
// ----------------------------------------------------------------------------
interface knfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] nearest_id;
  logic [3:0]  rank;
  logic        found;
  logic        last_result;

  modport source (
    output valid, nearest_id, rank, found, last_result,
    input  ready
  );
  modport sink (
    input  valid, nearest_id, rank, found, last_result,
    output ready
  );
endinterface

[src/knfs_ctrl.sv]
// ----------------------------------------------------------------------------
// knfs_ctrl: sequencing controller
// Walks each node through distance, insert and, at the end of a search,
// result emission.
// ----------------------------------------------------------------------------
module knfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  knfs_pkg::dp_sts_t sts,
  output knfs_pkg::dp_cmd_t cmd
);
  import knfs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_INS  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_INS;
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.final_beat) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && sts.in_valid) |=> state_r == ST_MUL)
    else $error("accepted node did not enter the distance pipeline");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && sts.out_free && sts.final_beat) |=> state_r == ST_IDLE)
    else $error("emission did not stop after the final beat");
`endif

endmodule

[src/knfs_dp.sv]
// ----------------------------------------------------------------------------
// knfs_dp: distance pipeline, sorted kept list and result register
// Holds the query registers, computes squared distance in stages and keeps
// a row of cells sorted by distance; emission shifts the row toward cell 0.
// ----------------------------------------------------------------------------
module knfs_dp #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int COORD_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  knfs_in_if.sink                             in_chan,
  knfs_out_if.source                          out_chan,
  input  logic                                cfg_wr_en,
  input  logic [knfs_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [knfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  knfs_pkg::dp_cmd_t                   cmd,
  output knfs_pkg::dp_sts_t                   sts
);
  import knfs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * COORD_BITS;
  localparam int DW = 2 * COORD_BITS + 1;
  localparam int CW = $clog2(MAX_NEIGHBORS + 1);
  localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

  // configuration
  logic [CFG_DATA_W-1:0] qx_r, qy_r;
  logic [NCOUNT_W-1:0]   nc_r;
  logic [CW-1:0]         eff_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
      nc_r <= NCOUNT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_QUERY_X:        qx_r <= cfg_wdata;
        CFG_QUERY_Y:        qy_r <= cfg_wdata;
        CFG_NEIGHBOR_COUNT: nc_r <= cfg_wdata[NCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nc_r == '0)                      eff_k = CW'(1);
    else if (int'(nc_r) > MAX_NEIGHBORS) eff_k = CW'(MAX_NEIGHBORS);
    else                                 eff_k = CW'(nc_r);
  end

  // distance pipeline
  logic              accept;
  logic [CB-1:0]     nx, ny, qx, qy;
  logic [CB-1:0]     dx_r, dy_r;
  logic [PW-1:0]     sqx_r, sqy_r;
  logic [DW-1:0]     dist_r;
  logic [ID_W-1:0]   id_r;
  logic              cand_r, last_r;

  assign accept = cmd.take & in_chan.valid;
  assign in_chan.ready = cmd.take;
  assign nx = CB'(in_chan.node_x);
  assign ny = CB'(in_chan.node_y);
  assign qx = CB'(qx_r);
  assign qy = CB'(qy_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r   <= (qx >= nx) ? qx - nx : nx - qx;
      dy_r   <= (qy >= ny) ? qy - ny : ny - qy;
      id_r   <= in_chan.node_id;
      cand_r <= !in_chan.outside_map && (in_chan.cell_cost < COST_LIMIT);
    end
    if (cmd.mul) begin
      sqx_r <= PW'(dx_r) * PW'(dx_r);
      sqy_r <= PW'(dy_r) * PW'(dy_r);
    end
    if (cmd.sum) dist_r <= DW'(sqx_r) + DW'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      last_r <= 1'b0;
    else if (accept) last_r <= in_chan.last_node;
  end

  // kept list
  logic [ID_W-1:0] kid_r   [MAX_NEIGHBORS];
  logic [DW-1:0]   kd_r    [MAX_NEIGHBORS];
  logic [ID_W-1:0] kid_nxt [MAX_NEIGHBORS];
  logic [DW-1:0]   kd_nxt  [MAX_NEIGHBORS];
  logic [ID_W-1:0] up_id   [MAX_NEIGHBORS];
  logic [DW-1:0]   up_d    [MAX_NEIGHBORS];
  logic [ID_W-1:0] dn_id   [MAX_NEIGHBORS];
  logic [DW-1:0]   dn_d    [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] le, le_prev;
  logic [CW-1:0]   count_r, count_nxt, cnt_eff;
  logic [IW-1:0]   km1;
  logic            room, do_ins;
  logic [RANK_W-1:0] rank_r;

  // neighbor taps: cell i-1 for insert shift, cell i+1 for emit shift
  always_comb begin
    up_id[0] = id_r;
    up_d[0]  = dist_r;
    for (int i = 1; i < MAX_NEIGHBORS; i++) begin
      up_id[i] = kid_r[i-1];
      up_d[i]  = kd_r[i-1];
    end
    dn_id[MAX_NEIGHBORS-1] = kid_r[MAX_NEIGHBORS-1];
    dn_d[MAX_NEIGHBORS-1]  = kd_r[MAX_NEIGHBORS-1];
    for (int i = 0; i < MAX_NEIGHBORS - 1; i++) begin
      dn_id[i] = kid_r[i+1];
      dn_d[i]  = kd_r[i+1];
    end
  end

  always_comb begin
    cnt_eff = (count_r > eff_k) ? eff_k : count_r;
    for (int i = 0; i < MAX_NEIGHBORS; i++)
      le[i] = (CW'(i) < cnt_eff) && (kd_r[i] <= dist_r);
    le_prev[0] = 1'b1;
    for (int i = 1; i < MAX_NEIGHBORS; i++) le_prev[i] = le[i-1];
    km1    = IW'(eff_k - CW'(1));
    room   = !le[km1];
    do_ins = cand_r && room;

    count_nxt = count_r;
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      kid_nxt[i] = kid_r[i];
      kd_nxt[i]  = kd_r[i];
    end

    if (cmd.insert) begin
      count_nxt = (do_ins && cnt_eff < eff_k) ? cnt_eff + CW'(1) : cnt_eff;
      if (do_ins) begin
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
          if (!le[i]) begin
            if (le_prev[i]) begin
              kid_nxt[i] = id_r;
              kd_nxt[i]  = dist_r;
            end else begin
              kid_nxt[i] = up_id[i];
              kd_nxt[i]  = up_d[i];
            end
          end
        end
      end
    end else if (cmd.emit) begin
      // drop the head entry, advance the rest
      if (count_r != '0) count_nxt = count_r - CW'(1);
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        kid_nxt[i] = dn_id[i];
        kd_nxt[i]  = dn_d[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      kid_r[i] <= kid_nxt[i];
      kd_r[i]  <= kd_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rank_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.insert)    rank_r <= '0;
      else if (cmd.emit) rank_r <= rank_r + RANK_W'(1);
    end
  end

  // result register
  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_found_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (cmd.emit)      out_valid_r <= 1'b1;
    else if (out_chan.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_id_r    <= (count_r != '0) ? kid_r[0] : '0;
      out_rank_r  <= rank_r;
      out_found_r <= (count_r != '0);
      out_last_r  <= (count_r <= CW'(1));
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.nearest_id  = out_id_r;
  assign out_chan.rank        = out_rank_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.last_result = out_last_r;

  assign sts.in_valid   = in_chan.valid;
  assign sts.last       = last_r;
  assign sts.out_free   = !out_valid_r || out_chan.ready;
  assign sts.final_beat = (count_r <= CW'(1));

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> count_r <= eff_k)
    else $error("kept count exceeds neighbor count after insert");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_last_r && out_rank_r == '0))
    else $error("empty-search result is not a lone final beat");
`endif

endmodule

[src/k_nearest_free_node_select.sv]
// ----------------------------------------------------------------------------
// k_nearest_free_node_select: k nearest free graph nodes to a query point
// Streams graph nodes and reports the ids of the nearest free ones, sorted
// by exact squared Euclidean distance, ties in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Write query_x, query_y and neighbor_count on the cfg_ port while idle.
//   Stream nodes on in_chan, one beat per node. A node is kept only if it is
//   inside the map and its cell cost is below 254. The beat with last_node
//   set closes the search.
//   Each node passes through accept (coordinate deltas), square, sum and a
//   sorted insert that compares against every kept cell at once. The ready
//   of in_chan is high only in the idle (accept) state of the controller, so
//   a new node is taken only after the previous one has been inserted.
//   After the closing node, results leave on out_chan nearest first, one
//   beat per cycle while the receiver takes them; the last one carries
//   last_result. A search with no free node gives one beat with found low.
//   The output register holds a beat while out_chan.ready is low; emission
//   waits, and input stays stalled until the final beat is loaded. That
//   final beat may still wait while the next search starts.
//   Reset (rst_n low, synchronous) clears the kept list, the controller and
//   the output valid, and sets query 0,0 with neighbor_count 1.
// ----------------------------------------------------------------------------
module k_nearest_free_node_select #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int COORD_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  knfs_in_if.sink                         in_chan,
  knfs_out_if.source                      out_chan,
  input  logic                            cfg_wr_en,
  input  logic [knfs_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [knfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import knfs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequence each node through the datapath
  knfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // distance stages, sorted list and result register
  knfs_dp #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
